@@ sv/rcg_pkg.sv @@
// Shared constants, codes and handshake structs for the merge sort tree range counter.
// Used by rcg_ctrl, rcg_dp and range_count_greater_than_unit; depends on nothing.
package rcg_pkg;

  localparam int MAX_N       = 1024;
  localparam int IDX_W       = 10;               // element index
  localparam int LEN_W       = 11;               // length, counts, node sizes
  localparam int NODE_W      = 11;               // tree node index, 1..2*MAX_N-1
  localparam int NODES       = 2 * MAX_N;
  localparam int VAL_W       = 32;
  localparam int STORE_DEPTH = 11 * MAX_N;       // sum of all node list sizes
  localparam int ADDR_W      = 14;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BOUNDS  = 2'd1;
  localparam logic [1:0] STAT_UNBUILT = 2'd2;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_CLR     = 5'd0;
  localparam logic [OP_W-1:0] OP_IDLE    = 5'd1;
  localparam logic [OP_W-1:0] OP_SZ_RD   = 5'd2;
  localparam logic [OP_W-1:0] OP_SZ_WR   = 5'd3;
  localparam logic [OP_W-1:0] OP_ST_RD   = 5'd4;
  localparam logic [OP_W-1:0] OP_ST_WR   = 5'd5;
  localparam logic [OP_W-1:0] OP_LF_RD   = 5'd6;
  localparam logic [OP_W-1:0] OP_LF_WR   = 5'd7;
  localparam logic [OP_W-1:0] OP_MG_RD   = 5'd8;
  localparam logic [OP_W-1:0] OP_MG_RD2  = 5'd9;
  localparam logic [OP_W-1:0] OP_MG_SET  = 5'd10;
  localparam logic [OP_W-1:0] OP_MS_RD   = 5'd11;
  localparam logic [OP_W-1:0] OP_MS_WR   = 5'd12;
  localparam logic [OP_W-1:0] OP_FIN     = 5'd13;
  localparam logic [OP_W-1:0] OP_Q_TEST  = 5'd14;
  localparam logic [OP_W-1:0] OP_Q_RCHK  = 5'd15;
  localparam logic [OP_W-1:0] OP_Q_SHIFT = 5'd16;
  localparam logic [OP_W-1:0] OP_NRD     = 5'd17;
  localparam logic [OP_W-1:0] OP_NSET    = 5'd18;
  localparam logic [OP_W-1:0] OP_BCHK    = 5'd19;
  localparam logic [OP_W-1:0] OP_BCMP    = 5'd20;
  localparam logic [OP_W-1:0] OP_OUT     = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            accept;
  } cmd_t;

  typedef struct packed {
    logic is_build;
    logic is_query;
    logic q_direct;   // query answered without a tree walk
    logic clr_last;
    logic i_one;
    logic i_top;
    logic one_elem;
    logic ms_done;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic lo_lt_hi;
    logic out_free;
  } stat_t;

endpackage

@@ sv/range_count_greater_than_unit.sv @@
// Top level of the merge sort tree range counter: joins rcg_ctrl and rcg_dp.
// Depends on rcg_pkg, rcg_ctrl and rcg_dp.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    req_type elem_index elem_value query_left query_right threshold
//   out      out_valid / out_stall  count status
//   cfg      cfg_valid / cfg_ready  cfg_data (array_length)
//
// A load is written as it is accepted and raises no stall. A build runs the size, start and leaf
// phases, then merges the two child lists of each inner node into that node's sorted list.
// A query walks the tree levels and, for each covering node, runs a binary search over its
// sorted list, each step waiting on the registered read of the sorted list store, then one output step.
// After reset a clearing pass zeroes all 1024 entries of the element memory; in_stall is high meanwhile.
// in_stall is high while an item is at work; a stalled result holds in the output register.
module range_count_greater_than_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [rcg_pkg::IDX_W-1:0]         elem_index,
  input  logic signed [rcg_pkg::VAL_W-1:0]  elem_value,
  input  logic [rcg_pkg::LEN_W-1:0]         query_left,
  input  logic [rcg_pkg::LEN_W-1:0]         query_right,
  input  logic signed [rcg_pkg::VAL_W-1:0]  threshold,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rcg_pkg::LEN_W-1:0]         count,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcg_pkg::LEN_W-1:0]         cfg_data
);

  rcg_pkg::cmd_t  cmd;
  rcg_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  rcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .elem_index  (elem_index),
    .elem_value  (elem_value),
    .query_left  (query_left),
    .query_right (query_right),
    .threshold   (threshold),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .count       (count),
    .status      (status)
  );

endmodule

@@ sv/rcg_dp.sv @@
// Datapath of the range counter: element, size, start and sorted list memories,
// walk registers and the output register. Depends on rcg_pkg; driven by rcg_ctrl.
module rcg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  rcg_pkg::cmd_t                     cmd,
  output rcg_pkg::stat_t                    stat,
  input  logic [1:0]                        req_type,
  input  logic [rcg_pkg::IDX_W-1:0]         elem_index,
  input  logic signed [rcg_pkg::VAL_W-1:0]  elem_value,
  input  logic [rcg_pkg::LEN_W-1:0]         query_left,
  input  logic [rcg_pkg::LEN_W-1:0]         query_right,
  input  logic signed [rcg_pkg::VAL_W-1:0]  threshold,
  input  logic                              cfg_valid,
  input  logic [rcg_pkg::LEN_W-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rcg_pkg::LEN_W-1:0]         count,
  output logic [1:0]                        status
);

  logic signed [rcg_pkg::VAL_W-1:0] elem_mem [rcg_pkg::MAX_N];
  logic [rcg_pkg::LEN_W-1:0]        size_mem [rcg_pkg::NODES];
  logic [rcg_pkg::ADDR_W-1:0]       start_mem [rcg_pkg::NODES];
  logic signed [rcg_pkg::VAL_W-1:0] store_mem [rcg_pkg::STORE_DEPTH];

  logic [rcg_pkg::LEN_W-1:0]  nlen;
  logic                       built;
  logic [rcg_pkg::IDX_W-1:0]  clr;
  logic [rcg_pkg::NODE_W-1:0] i;
  logic [rcg_pkg::ADDR_W-1:0] acc, pa, pae, pb, pbe, po, base;
  logic [rcg_pkg::LEN_W-1:0]  lo, hi, mid, sz, cnt;
  logic [rcg_pkg::NODE_W:0]   l, r;
  logic [rcg_pkg::NODE_W-1:0] node;
  logic signed [rcg_pkg::VAL_W-1:0] k;
  logic [1:0]                 qstat;

  logic signed [rcg_pkg::VAL_W-1:0] elem_rd, st_rda, st_rdb;
  logic [rcg_pkg::LEN_W-1:0]        size_rda, size_rdb;
  logic [rcg_pkg::ADDR_W-1:0]       start_rda, start_rdb;

  logic [rcg_pkg::NODE_W-1:0] top, i2, i2p;
  logic [rcg_pkg::NODE_W-1:0] size_ra, size_rb, start_ra, start_rb;
  logic [rcg_pkg::ADDR_W-1:0] st_ra, st_rb;
  logic [rcg_pkg::LEN_W-1:0]  mid_c, cfg_len;
  logic                       a_live, b_live, take_a;
  logic [rcg_pkg::ADDR_W-1:0] na, nb;
  logic                       bad;
  logic                       is_load;

  assign top = rcg_pkg::NODE_W'({1'b0, nlen, 1'b0} - 13'd1);
  assign i2  = {i[rcg_pkg::NODE_W-2:0], 1'b0};
  assign i2p = {i[rcg_pkg::NODE_W-2:0], 1'b1};
  assign mid_c = lo + ((hi - lo) >> 1);

  assign a_live = pa < pae;
  assign b_live = pb < pbe;
  assign take_a = !b_live || (a_live && (st_rda <= st_rdb));
  assign na = take_a ? pa + 1'b1 : pa;
  assign nb = take_a ? pb : pb + 1'b1;

  assign bad = (query_left == '0) || (query_left > nlen) ||
               (query_right == '0) || (query_right > nlen);
  assign is_load = cmd.accept && (req_type == rcg_pkg::REQ_LOAD);

  // A zero length counts as one, anything above the array size as the array size.
  always_comb begin
    cfg_len = cfg_data;
    if (cfg_data == '0) begin
      cfg_len = rcg_pkg::LEN_W'(1);
    end else if (cfg_data > rcg_pkg::LEN_W'(rcg_pkg::MAX_N)) begin
      cfg_len = rcg_pkg::LEN_W'(rcg_pkg::MAX_N);
    end
  end

  always_comb begin
    size_ra  = i;
    size_rb  = i2p;
    start_ra = i;
    start_rb = i2p;
    st_ra    = pa;
    st_rb    = pb;
    case (cmd.op)
      rcg_pkg::OP_SZ_RD: size_ra = i2;
      rcg_pkg::OP_MG_RD: begin
        size_ra  = i2;
        start_ra = i2;
      end
      rcg_pkg::OP_NRD: begin
        size_ra  = node;
        start_ra = node;
      end
      rcg_pkg::OP_BCHK: st_ra = base + rcg_pkg::ADDR_W'(mid_c);
      default: ;
    endcase
  end

  // Memory ports: registered reads, one write port each.
  always_ff @(posedge clk) begin
    elem_rd   <= elem_mem[rcg_pkg::IDX_W'(i - nlen)];
    size_rda  <= size_mem[size_ra];
    size_rdb  <= size_mem[size_rb];
    start_rda <= start_mem[start_ra];
    start_rdb <= start_mem[start_rb];
    st_rda    <= store_mem[st_ra];
    st_rdb    <= store_mem[st_rb];
    if (cmd.op == rcg_pkg::OP_CLR) begin
      elem_mem[clr] <= '0;
    end else if (is_load) begin
      elem_mem[elem_index] <= elem_value;
    end
    if (cmd.op == rcg_pkg::OP_SZ_WR) begin
      size_mem[i] <= (i >= nlen) ? rcg_pkg::LEN_W'(1) : size_rda + size_rdb;
    end
    if (cmd.op == rcg_pkg::OP_ST_WR) begin
      start_mem[i] <= acc;
    end
    if (cmd.op == rcg_pkg::OP_LF_WR) begin
      store_mem[start_rda] <= elem_rd;
    end else if (cmd.op == rcg_pkg::OP_MS_WR) begin
      store_mem[po] <= take_a ? st_rda : st_rdb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nlen      <= rcg_pkg::LEN_W'(1);
      built     <= 1'b0;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        nlen <= cfg_len;
      end
      // A length write or a load leaves the tree stale.
      if (cfg_valid || is_load) begin
        built <= 1'b0;
      end else if (cmd.op == rcg_pkg::OP_FIN) begin
        built <= 1'b1;
      end
      if (cmd.op == rcg_pkg::OP_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        rcg_pkg::OP_CLR: clr <= clr + 1'b1;
        rcg_pkg::OP_IDLE: begin
          if (cmd.accept) begin
            i     <= top;
            cnt   <= '0;
            k     <= threshold;
            l     <= {1'b0, nlen} + {1'b0, query_left} - 1'b1;
            r     <= {1'b0, nlen} + {1'b0, query_right};
            qstat <= !built ? rcg_pkg::STAT_UNBUILT :
                     bad    ? rcg_pkg::STAT_BOUNDS  : rcg_pkg::STAT_OK;
          end
        end
        rcg_pkg::OP_SZ_WR: begin
          if (i == rcg_pkg::NODE_W'(1)) begin
            acc <= '0;
          end else begin
            i <= i - 1'b1;
          end
        end
        rcg_pkg::OP_ST_WR: begin
          acc <= acc + rcg_pkg::ADDR_W'(size_rda);
          i   <= (i == top) ? nlen : i + 1'b1;
        end
        rcg_pkg::OP_LF_WR: begin
          i <= (i == top) ? nlen - 1'b1 : i + 1'b1;
        end
        rcg_pkg::OP_MG_RD2: begin
          pa  <= start_rda;
          pae <= start_rda + rcg_pkg::ADDR_W'(size_rda);
          pb  <= start_rdb;
          pbe <= start_rdb + rcg_pkg::ADDR_W'(size_rdb);
        end
        rcg_pkg::OP_MG_SET: po <= start_rda;
        rcg_pkg::OP_MS_WR: begin
          pa <= na;
          pb <= nb;
          po <= po + 1'b1;
          if (na >= pae && nb >= pbe) begin
            i <= i - 1'b1;
          end
        end
        rcg_pkg::OP_Q_TEST: begin
          if (l < r && l[0]) begin
            node <= l[rcg_pkg::NODE_W-1:0];
            l    <= l + 1'b1;
          end
        end
        rcg_pkg::OP_Q_RCHK: begin
          if (r[0]) begin
            node <= rcg_pkg::NODE_W'(r - 1'b1);
            r    <= r - 1'b1;
          end
        end
        rcg_pkg::OP_Q_SHIFT: begin
          l <= l >> 1;
          r <= r >> 1;
        end
        rcg_pkg::OP_NSET: begin
          base <= start_rda;
          sz   <= size_rda;
          hi   <= size_rda;
          lo   <= '0;
        end
        rcg_pkg::OP_BCHK: begin
          if (lo < hi) begin
            mid <= mid_c;
          end else begin
            cnt <= cnt + (sz - lo);
          end
        end
        rcg_pkg::OP_BCMP: begin
          if (st_rda <= k) begin
            lo <= mid + 1'b1;
          end else begin
            hi <= mid;
          end
        end
        rcg_pkg::OP_OUT: begin
          if (!out_valid || !out_stall) begin
            count  <= cnt;
            status <= qstat;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.is_build = req_type == rcg_pkg::REQ_BUILD;
    stat.is_query = req_type == rcg_pkg::REQ_QUERY;
    stat.q_direct = !built || bad || (query_left > query_right);
    stat.clr_last = clr == '1;
    stat.i_one    = i == rcg_pkg::NODE_W'(1);
    stat.i_top    = i == top;
    stat.one_elem = nlen == rcg_pkg::LEN_W'(1);
    stat.ms_done  = (na >= pae) && (nb >= pbe);
    stat.l_lt_r   = l < r;
    stat.l_odd    = l[0];
    stat.r_odd    = r[0];
    stat.lo_lt_hi = lo < hi;
    stat.out_free = !out_valid || !out_stall;
  end

  a_fin_built: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rcg_pkg::OP_FIN && !cfg_valid) |=> built)
    else $error("build finished without setting the built flag");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == rcg_pkg::OP_OUT))
    else $error("result raised outside the output step");
  a_po_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rcg_pkg::OP_MS_WR) |-> (po < rcg_pkg::ADDR_W'(rcg_pkg::STORE_DEPTH)))
    else $error("merge write beyond the sorted list store");
  a_search: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rcg_pkg::OP_BCMP) |-> (lo < hi && mid >= lo && mid < hi))
    else $error("binary search midpoint outside its window");

endmodule

@@ sv/rcg_ctrl.sv @@
// Sequencer of the range counter: clear pass, build phases, query walk, output.
// Depends on rcg_pkg; issues one command a cycle to rcg_dp.
module rcg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     req_type,
  input  rcg_pkg::stat_t stat,
  output rcg_pkg::cmd_t  cmd
);

  logic [rcg_pkg::OP_W-1:0] state, state_next;
  logic ret, ret_next;   // after a node search: 0 checks the right edge, 1 shifts

  assign in_stall   = state != rcg_pkg::OP_IDLE;
  assign cmd.op     = state;
  assign cmd.accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      rcg_pkg::OP_CLR: if (stat.clr_last) state_next = rcg_pkg::OP_IDLE;
      rcg_pkg::OP_IDLE: begin
        if (cmd.accept && stat.is_build) begin
          state_next = rcg_pkg::OP_SZ_RD;
        end else if (cmd.accept && stat.is_query) begin
          state_next = stat.q_direct ? rcg_pkg::OP_OUT : rcg_pkg::OP_Q_TEST;
        end
      end
      rcg_pkg::OP_SZ_RD: state_next = rcg_pkg::OP_SZ_WR;
      rcg_pkg::OP_SZ_WR: state_next = stat.i_one ? rcg_pkg::OP_ST_RD : rcg_pkg::OP_SZ_RD;
      rcg_pkg::OP_ST_RD: state_next = rcg_pkg::OP_ST_WR;
      rcg_pkg::OP_ST_WR: state_next = stat.i_top ? rcg_pkg::OP_LF_RD : rcg_pkg::OP_ST_RD;
      rcg_pkg::OP_LF_RD: state_next = rcg_pkg::OP_LF_WR;
      rcg_pkg::OP_LF_WR: begin
        if (stat.i_top) begin
          state_next = stat.one_elem ? rcg_pkg::OP_FIN : rcg_pkg::OP_MG_RD;
        end else begin
          state_next = rcg_pkg::OP_LF_RD;
        end
      end
      rcg_pkg::OP_MG_RD:  state_next = rcg_pkg::OP_MG_RD2;
      rcg_pkg::OP_MG_RD2: state_next = rcg_pkg::OP_MG_SET;
      rcg_pkg::OP_MG_SET: state_next = rcg_pkg::OP_MS_RD;
      rcg_pkg::OP_MS_RD:  state_next = rcg_pkg::OP_MS_WR;
      rcg_pkg::OP_MS_WR: begin
        if (stat.ms_done) begin
          state_next = stat.i_one ? rcg_pkg::OP_FIN : rcg_pkg::OP_MG_RD;
        end else begin
          state_next = rcg_pkg::OP_MS_RD;
        end
      end
      rcg_pkg::OP_FIN: state_next = rcg_pkg::OP_IDLE;
      rcg_pkg::OP_Q_TEST: begin
        if (!stat.l_lt_r) begin
          state_next = rcg_pkg::OP_OUT;
        end else if (stat.l_odd) begin
          state_next = rcg_pkg::OP_NRD;
          ret_next   = 1'b0;
        end else begin
          state_next = rcg_pkg::OP_Q_RCHK;
        end
      end
      rcg_pkg::OP_Q_RCHK: begin
        if (stat.r_odd) begin
          state_next = rcg_pkg::OP_NRD;
          ret_next   = 1'b1;
        end else begin
          state_next = rcg_pkg::OP_Q_SHIFT;
        end
      end
      rcg_pkg::OP_Q_SHIFT: state_next = rcg_pkg::OP_Q_TEST;
      rcg_pkg::OP_NRD:     state_next = rcg_pkg::OP_NSET;
      rcg_pkg::OP_NSET:    state_next = rcg_pkg::OP_BCHK;
      rcg_pkg::OP_BCHK: begin
        if (stat.lo_lt_hi) begin
          state_next = rcg_pkg::OP_BCMP;
        end else begin
          state_next = ret ? rcg_pkg::OP_Q_SHIFT : rcg_pkg::OP_Q_RCHK;
        end
      end
      rcg_pkg::OP_BCMP: state_next = rcg_pkg::OP_BCHK;
      rcg_pkg::OP_OUT:  if (stat.out_free) state_next = rcg_pkg::OP_IDLE;
      default: state_next = rcg_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcg_pkg::OP_CLR;
      ret   <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  a_build_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && req_type == rcg_pkg::REQ_BUILD) |=> state == rcg_pkg::OP_SZ_RD)
    else $error("accepted build did not start the size phase");
  a_query_exit: assert property (@(posedge clk) disable iff (rst)
    (state == rcg_pkg::OP_Q_TEST && !stat.l_lt_r) |=> state == rcg_pkg::OP_OUT)
    else $error("finished walk did not reach the output step");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == rcg_pkg::OP_OUT && !stat.out_free) |=> state == rcg_pkg::OP_OUT)
    else $error("result step left while the output register was full");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for range_count_greater_than_unit, the merge sort tree range counter.
// It predicts each query answer from its own copy of the element array, length and build state.
// Depends on rcg_pkg and the RTL of the unit.
`timescale 1ns / 100ps

class range_count_board;
  logic signed [rcg_pkg::VAL_W-1:0] elems [rcg_pkg::MAX_N];
  int unsigned length;
  bit built;
  int fails;
  logic [rcg_pkg::LEN_W-1:0] want_count [$];
  logic [1:0] want_status [$];

  function void reset_state();
    foreach (elems[i]) elems[i] = '0;
    length = 1;
    built = 0;
    fails = 0;
  endfunction

  function void set_length(logic [rcg_pkg::LEN_W-1:0] v);
    length = (v == 0) ? 1 : (v > rcg_pkg::MAX_N) ? rcg_pkg::MAX_N : v;
    built = 0;
  endfunction

  // Notes one accepted request beat and, for a query, queues the answer it must produce.
  function void note_request(logic [1:0] kind, logic [rcg_pkg::IDX_W-1:0] idx,
                             logic signed [rcg_pkg::VAL_W-1:0] val,
                             logic [rcg_pkg::LEN_W-1:0] lft, logic [rcg_pkg::LEN_W-1:0] rgt,
                             logic signed [rcg_pkg::VAL_W-1:0] th);
    int unsigned cnt;
    cnt = 0;
    if (kind == rcg_pkg::REQ_LOAD) begin
      elems[idx] = val;
      built = 0;
    end else if (kind == rcg_pkg::REQ_BUILD) begin
      built = 1;
    end else if (kind == rcg_pkg::REQ_QUERY) begin
      if (!built) begin
        want_status = {want_status, rcg_pkg::STAT_UNBUILT};
      end else if (lft < 1 || lft > length || rgt < 1 || rgt > length) begin
        want_status = {want_status, rcg_pkg::STAT_BOUNDS};
      end else begin
        // The tree holds exactly the loaded elements, so a direct scan gives the same count.
        for (int i = lft - 1; i < rgt; i++)
          if (elems[i] > th) cnt++;
        want_status = {want_status, rcg_pkg::STAT_OK};
      end
      want_count = {want_count, rcg_pkg::LEN_W'(cnt)};
    end
  endfunction

  function void check_answer(logic [rcg_pkg::LEN_W-1:0] cnt, logic [1:0] st);
    logic [rcg_pkg::LEN_W-1:0] ec;
    logic [1:0] es;
    if (want_count.size() == 0) begin
      $error("answer beat with none expected: count %0d status %0d", cnt, st);
      fails++;
    end else begin
      ec = want_count.pop_front();
      es = want_status.pop_front();
      if (cnt !== ec) begin
        $error("count: expected %0d, actual %0d", ec, cnt);
        fails++;
      end
      if (st !== es) begin
        $error("status: expected %0d, actual %0d", es, st);
        fails++;
      end
    end
  endfunction
endclass

module testbench;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE = 800;
  localparam int LOAD_CAP = 32;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic [1:0] req_type, status;
  logic [rcg_pkg::IDX_W-1:0] elem_index;
  logic signed [rcg_pkg::VAL_W-1:0] elem_value, threshold;
  logic [rcg_pkg::LEN_W-1:0] query_left, query_right, count, cfg_data;

  range_count_board board;
  bit calm;
  int cycles;

  range_count_greater_than_unit uut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(99) < 26);

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) board.check_answer(count, status);

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send(logic [1:0] kind, int idx, logic [31:0] val,
                      int lft, int rgt, logic [31:0] th);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    elem_index <= rcg_pkg::IDX_W'(idx);
    elem_value <= val;
    query_left <= rcg_pkg::LEN_W'(lft);
    query_right <= rcg_pkg::LEN_W'(rgt);
    threshold <= th;
    do @(posedge clk); while (in_stall);
    board.note_request(kind, rcg_pkg::IDX_W'(idx), val, rcg_pkg::LEN_W'(lft),
                       rcg_pkg::LEN_W'(rgt), th);
    @(negedge clk);
  endtask

  task automatic load(int idx, logic [31:0] val);
    send(rcg_pkg::REQ_LOAD, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic build();
    send(rcg_pkg::REQ_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic query(int lft, int rgt, logic [31:0] th);
    send(rcg_pkg::REQ_QUERY, $urandom, $urandom, lft, rgt, th);
  endtask

  // Drains every expected answer, then lets the unit settle before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.want_count.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_length(int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= rcg_pkg::LEN_W'(v);
    do @(posedge clk); while (!cfg_ready);
    board.set_length(rcg_pkg::LEN_W'(v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value(bit narrow);
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return narrow ? 32'($urandom_range(8) - 4) : $urandom;
    endcase
  endfunction

  // Thresholds lean toward stored values so the strict comparison is hit at equality.
  function automatic logic [31:0] pick_threshold(int n);
    logic [31:0] e;
    e = board.elems[$urandom_range(n - 1)];
    case ($urandom_range(5))
      0: return e;
      1: return e - 1;
      2: return e + 1;
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int len_word, int n_queries, bit narrow);
    int n, l, r;
    write_length(len_word);
    n = board.length;
    // Long arrays get a scattered handful of loads; the rest keep their earlier values.
    if (n <= LOAD_CAP) begin
      for (int i = 0; i < n; i++) load(i, pick_value(narrow));
    end else begin
      repeat (LOAD_CAP) load($urandom_range(n - 1), pick_value(narrow));
    end
    if ($urandom_range(3) == 0) query($urandom_range(1, n), n, $urandom);
    build();
    for (int q = 0; q < n_queries; q++) begin
      calm = (q >= 20 && q < 45);
      case ($urandom_range(99)) inside
        [0:64]: begin
          l = $urandom_range(1, n);
          r = $urandom_range(l, n);
          query(l, r, pick_threshold(n));
        end
        [65:72]: begin
          l = $urandom_range(1, n);
          r = $urandom_range(1, n);
          query(l > r ? l : r, l > r ? r : l, pick_threshold(n));
        end
        [73:84]: query($urandom_range(2047), $urandom_range(2047), $urandom);
        [85:92]: begin
          load($urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(1023),
               pick_value(narrow));
          if ($urandom_range(2) != 0) build();
        end
        [93:95]: send(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: build();
      endcase
    end
    calm = 0;
    query(1, n, pick_threshold(n));
  endtask

  initial begin
    board = new();
    board.reset_state();
    calm = 0;
    cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    req_type = rcg_pkg::REQ_LOAD;
    elem_index = '0;
    elem_value = '0;
    query_left = '0;
    query_right = '0;
    threshold = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset length of one element.
    query(1, 1, 0);
    load(0, 32'h7fff_ffff);
    build();
    query(1, 1, 32'h7fff_fffe);
    query(1, 1, 32'h7fff_ffff);
    query(0, 1, 0);
    query(1, 2, 0);
    send(REQ_UNUSED, 0, 0, 1, 1, 0);
    query(1, 1, 32'h8000_0000);

    write_length(4);
    load(0, 32'h8000_0000);
    load(1, 32'h7fff_ffff);
    load(2, 0);
    load(3, 32'hffff_ffff);
    load(1023, 5);
    build();
    query(1, 4, 32'h8000_0000);
    query(1, 4, 32'hffff_ffff);
    query(3, 2, 32'h8000_0000);
    query(5, 4, 0);
    query(1, 2047, 0);
    query(2, 3, 32'hffff_ffff);
    load(2, 7);
    query(1, 4, 0);

    random_phase(0, 40, 1);
    random_phase(2, 60, 1);
    random_phase(3, 60, 0);
    random_phase(5, 80, 1);
    random_phase(8, 80, 0);
    random_phase(17, 100, 1);
    random_phase(1024, 100, 0);
    random_phase(33, 120, 1);
    random_phase(100, 120, 0);
    random_phase(2047, 60, 1);
    random_phase(64, 120, 1);
    random_phase(11'h555, 20, 0);
    random_phase(11'h2aa, 60, 1);

    drain();
    if (board.fails == 0 && board.want_count.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/rcg_pkg.sv
sv/rcg_dp.sv
sv/rcg_ctrl.sv
sv/range_count_greater_than_unit.sv
tb/testbench.sv
